FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the pixel command generator.
// Depends on nothing; define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// Condition that never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

FILE: hdl/bpcg_pkg.sv
// Types and constants of the bitmap pixel command generator.
// Depends on nothing; used by every module of the block.
`default_nettype none
package bpcg_pkg;

    // Display controller command bytes.
    localparam logic [7:0] CMD_COLUMN = 8'h2A;
    localparam logic [7:0] CMD_ROW    = 8'h2B;
    localparam logic [7:0] CMD_WRITE  = 8'h2C;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_FG_COLOR = 3'd4;

    // Position of a byte within a pixel's nine-byte sequence.
    localparam int SEQ_W = 4;
    localparam logic [SEQ_W-1:0] SEQ_CASET    = 4'd0;
    localparam logic [SEQ_W-1:0] SEQ_XHI      = 4'd1;
    localparam logic [SEQ_W-1:0] SEQ_XLO      = 4'd2;
    localparam logic [SEQ_W-1:0] SEQ_RASET    = 4'd3;
    localparam logic [SEQ_W-1:0] SEQ_YHI      = 4'd4;
    localparam logic [SEQ_W-1:0] SEQ_YLO      = 4'd5;
    localparam logic [SEQ_W-1:0] SEQ_RAMWR    = 4'd6;
    localparam logic [SEQ_W-1:0] SEQ_COL_HI   = 4'd7;
    localparam logic [SEQ_W-1:0] SEQ_COL_LO   = 4'd8;

    // Pixel queue depth.
    localparam int QUEUE_DEPTH = 2;

    // Configuration write.
    typedef struct packed {
        logic                  we;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] wdata;
    } t_cfg_wr;

    // One classified pixel, ready to be turned into bytes.
    typedef struct packed {
        logic [7:0]  x_addr;
        logic [7:0]  y_addr;
        logic [15:0] colour;
        logic        image_last;
    } t_pix_cmd;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_stat;

endpackage
`default_nettype wire

FILE: hdl/bpcg_front.sv
// Front end: configuration registers, position counters and pixel classification.
// Depends on bpcg_pkg.
`default_nettype none
module bpcg_front #(
    parameter int COORD_BITS = 8
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  bpcg_pkg::t_cfg_wr        i_cfg,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire                      i_pixel_on,
    input  bpcg_pkg::t_queue_stat    i_stat,
    output logic                     o_push,
    output bpcg_pkg::t_pix_cmd       o_cmd
);

    logic [7:0]            r_origin_x;
    logic [7:0]            r_origin_y;
    logic [7:0]            r_width;
    logic [7:0]            r_height;
    logic [15:0]           r_fg_color;
    logic [COORD_BITS-1:0] r_col;
    logic [COORD_BITS-1:0] r_row;
    logic [COORD_BITS-1:0] n_col;
    logic [COORD_BITS-1:0] n_row;

    logic [COORD_BITS:0]   col_p1;
    logic [COORD_BITS:0]   row_p1;
    logic                  row_end;
    logic                  col_end;

    // A word is taken whenever the queue has room.
    assign o_ready = !i_stat.full;
    assign o_push  = i_valid && !i_stat.full;

    // End-of-row and end-of-image tests; a limit of zero behaves as one.
    assign col_p1  = {1'b0, r_col} + {{COORD_BITS{1'b0}}, 1'b1};
    assign row_p1  = {1'b0, r_row} + {{COORD_BITS{1'b0}}, 1'b1};
    assign row_end = col_p1 >= {{(COORD_BITS - 7){1'b0}}, r_width};
    assign col_end = row_p1 >= {{(COORD_BITS - 7){1'b0}}, r_height};

    // Classified pixel; panel addresses wrap at eight bits.
    always_comb begin
        o_cmd.x_addr     = 8'(r_origin_x + r_col[7:0]);
        o_cmd.y_addr     = 8'(r_origin_y + r_row[7:0]);
        o_cmd.colour     = i_pixel_on ? r_fg_color : 16'h0000;
        o_cmd.image_last = row_end && col_end;
    end

    // Next position in raster order.
    always_comb begin
        if (row_end) begin
            n_col = '0;
            n_row = col_end ? '0 : row_p1[COORD_BITS-1:0];
        end else begin
            n_col = col_p1[COORD_BITS-1:0];
            n_row = r_row;
        end
    end

    // Registers and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= 8'd0;
            r_origin_y <= 8'd0;
            r_width    <= 8'd1;
            r_height   <= 8'd1;
            r_fg_color <= 16'hFFFF;
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            if (i_cfg.we) begin
                case (i_cfg.addr)
                    bpcg_pkg::CFG_ORIGIN_X: r_origin_x <= i_cfg.wdata[7:0];
                    bpcg_pkg::CFG_ORIGIN_Y: r_origin_y <= i_cfg.wdata[7:0];
                    bpcg_pkg::CFG_WIDTH:    r_width    <= i_cfg.wdata[7:0];
                    bpcg_pkg::CFG_HEIGHT:   r_height   <= i_cfg.wdata[7:0];
                    bpcg_pkg::CFG_FG_COLOR: r_fg_color <= i_cfg.wdata;
                    default: begin
                    end
                endcase
            end
            if (o_push) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hdl/bpcg_queue.sv
// Two-entry pixel queue between the front end and the byte sequencer.
// Depends on bpcg_pkg.
`default_nettype none
module bpcg_queue (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_push,
    input  bpcg_pkg::t_pix_cmd       i_cmd,
    input  wire                      i_pop,
    output bpcg_pkg::t_pix_cmd       o_head,
    output bpcg_pkg::t_queue_stat    o_stat
);

    localparam int PTR_W = $clog2(bpcg_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(bpcg_pkg::QUEUE_DEPTH + 1);

    bpcg_pkg::t_pix_cmd r_mem [bpcg_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.empty = r_count == '0;
    assign o_stat.full  = r_count == CNT_W'(bpcg_pkg::QUEUE_DEPTH);

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= PTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= PTR_W'(r_rd_ptr + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (i_pop && !i_push) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

endmodule
`default_nettype wire

FILE: hdl/bpcg_back.sv
// Back end: expands each queued pixel into its nine controller bytes.
// Depends on bpcg_pkg.
`default_nettype none
module bpcg_back (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  bpcg_pkg::t_pix_cmd       i_head,
    input  bpcg_pkg::t_queue_stat    i_stat,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire                      i_ready,
    output logic [7:0]               o_byte,
    output logic                     o_is_data,
    output logic                     o_pixel_last,
    output logic                     o_image_last
);

    bpcg_pkg::t_pix_cmd           r_ent;
    logic [bpcg_pkg::SEQ_W-1:0]   r_idx;
    logic                         r_valid;
    logic [7:0]                   r_byte;
    logic                         r_is_data;
    logic                         r_plast;
    logic                         r_ilast;

    logic                         can_load;
    logic                         emit;
    logic [7:0]                   n_byte;
    logic                         n_is_data;

    // The output register loads when empty or when its word is taken.
    assign can_load = !r_valid || i_ready;
    assign emit     = can_load && (r_idx != bpcg_pkg::SEQ_CASET || !i_stat.empty);
    assign o_pop    = emit && r_idx == bpcg_pkg::SEQ_CASET;

    // Byte for the current position in the sequence.
    always_comb begin
        case (r_idx)
            bpcg_pkg::SEQ_CASET: begin
                n_byte = bpcg_pkg::CMD_COLUMN;
                n_is_data = 1'b0;
            end
            bpcg_pkg::SEQ_XHI: begin
                n_byte = bpcg_pkg::ZERO_BYTE;
                n_is_data = 1'b1;
            end
            bpcg_pkg::SEQ_XLO: begin
                n_byte = r_ent.x_addr;
                n_is_data = 1'b1;
            end
            bpcg_pkg::SEQ_RASET: begin
                n_byte = bpcg_pkg::CMD_ROW;
                n_is_data = 1'b0;
            end
            bpcg_pkg::SEQ_YHI: begin
                n_byte = bpcg_pkg::ZERO_BYTE;
                n_is_data = 1'b1;
            end
            bpcg_pkg::SEQ_YLO: begin
                n_byte = r_ent.y_addr;
                n_is_data = 1'b1;
            end
            bpcg_pkg::SEQ_RAMWR: begin
                n_byte = bpcg_pkg::CMD_WRITE;
                n_is_data = 1'b0;
            end
            bpcg_pkg::SEQ_COL_HI: begin
                n_byte = r_ent.colour[15:8];
                n_is_data = 1'b1;
            end
            bpcg_pkg::SEQ_COL_LO: begin
                n_byte = r_ent.colour[7:0];
                n_is_data = 1'b1;
            end
            default: begin
                n_byte = bpcg_pkg::ZERO_BYTE;
                n_is_data = 1'b1;
            end
        endcase
    end

    // Sequence position and the held pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= bpcg_pkg::SEQ_CASET;
        end else if (emit) begin
            if (r_idx == bpcg_pkg::SEQ_COL_LO) begin
                r_idx <= bpcg_pkg::SEQ_CASET;
            end else begin
                r_idx <= bpcg_pkg::SEQ_W'(r_idx + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_head;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (can_load) begin
            r_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte    <= n_byte;
            r_is_data <= n_is_data;
            r_plast   <= r_idx == bpcg_pkg::SEQ_COL_LO;
            r_ilast   <= r_idx == bpcg_pkg::SEQ_COL_LO && r_ent.image_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_byte       = r_byte;
    assign o_is_data    = r_is_data;
    assign o_pixel_last = r_plast;
    assign o_image_last = r_ilast;

endmodule
`default_nettype wire

FILE: hdl/bitmap_pixel_command_generator.sv
// Bitmap pixel command generator: one bitmap bit in, nine controller bytes out.
// The accepted bit is written into the pixel queue, and its first byte then leaves
// through the byte-wide output register, nine bytes per pixel;
// a two-pixel queue lets input words be taken while bytes are still going out.
// Reset (synchronous, active low) clears counters, queue and output valid, and
// loads origin 0,0, size 1 by 1 and foreground colour 0xFFFF.
`default_nettype none
`include "assert_macros.svh"
module bitmap_pixel_command_generator #(
    parameter int COORD_BITS = 8
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // Configuration write port
    input  wire          i_cfg_we,
    input  wire  [2:0]   i_cfg_addr,
    input  wire  [15:0]  i_cfg_wdata,
    // Input stream
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [7:0]   s_axis_tdata,   // [0] pixel_on, [7:1] zero
    // Output stream
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [7:0]   m_axis_tdata,   // [7:0] out_byte
    output logic         m_axis_tlast,   // pixel_last
    output logic [1:0]   m_axis_tuser    // [0] is_data, [1] image_last
);

    bpcg_pkg::t_cfg_wr      cfg;
    bpcg_pkg::t_pix_cmd     push_cmd;
    bpcg_pkg::t_pix_cmd     head_cmd;
    bpcg_pkg::t_queue_stat  q_stat;
    logic                   push;
    logic                   pop;
    logic                   is_data;
    logic                   image_last;

    assign cfg.we    = i_cfg_we;
    assign cfg.addr  = i_cfg_addr;
    assign cfg.wdata = i_cfg_wdata;

    // Front end: classify each word.
    bpcg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_pixel_on (s_axis_tdata[0]),
        .i_stat     (q_stat),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // Pixel queue.
    bpcg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_stat  (q_stat)
    );

    // Back end: byte sequencer.
    bpcg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_cmd),
        .i_stat       (q_stat),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_byte       (m_axis_tdata),
        .o_is_data    (is_data),
        .o_pixel_last (m_axis_tlast),
        .o_image_last (image_last)
    );

    assign m_axis_tuser = {image_last, is_data};

    // The queue is never both full and empty.
    `ASSERT_NEVER(a_queue_stat, i_clk, i_rst_n, q_stat.full && q_stat.empty, "queue status")
    // The end of an image only falls on the last byte of a pixel.
    `ASSERT_IMPLY(a_ilast_plast, i_clk, i_rst_n, m_axis_tvalid && image_last, m_axis_tlast, "image_last without pixel_last")
    // The last byte of a pixel is a data byte.
    `ASSERT_IMPLY(a_plast_data, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, is_data, "pixel_last on a command byte")
    // After a pixel ends, the next byte out opens a column address command.
    `ASSERT_NEXT(a_seq_restart, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid || (m_axis_tdata == bpcg_pkg::CMD_COLUMN && !is_data), "sequence restart")

endmodule
`default_nettype wire

FILE: tb/bitmap_pixel_command_generator_tb.sv
// Self-checking testbench for the bitmap pixel command generator.
// Depends on bpcg_pkg and the bitmap_pixel_command_generator RTL; reads no files.
`timescale 1ns / 1ps
module bitmap_pixel_command_generator_tb;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int RAND_PHASES      = 8;
    localparam int PIXELS_PER_PHASE = 25;
    localparam int DRAIN_CYCLES     = 20;
    localparam int SCRIPT_LEN       = 37;

    // One byte bound for the display controller, as the block should emit it.
    typedef struct packed {
        logic [7:0] value;
        logic       is_data;
        logic       pixel_end;
        logic       image_end;
    } t_lcd_byte;

    // Rows of the directed script: a register write, or a pixel whose bytes
    // are either predicted or typed in directly.
    typedef enum logic [1:0] {ROW_CFG, ROW_PIXEL, ROW_PIXEL_KNOWN} t_row_kind;

    typedef struct packed {
        t_row_kind                       kind;
        logic [bpcg_pkg::CFG_ADDR_W-1:0] idx;
        logic [15:0]                     value;
        logic [7:0]                      x;
        logic [7:0]                      y;
        logic [15:0]                     colour;
        logic                            last;
    } t_script_row;

    // Reset state first, then both origins at their top with a 2 by 2 image so
    // that the addresses wrap, zero width and height, a large image cut short
    // in mid-row, and origin and colour changed in mid-image.
    t_script_row script [SCRIPT_LEN] = '{
        '{ROW_PIXEL_KNOWN, '0, 16'd1, 8'h00, 8'h00, 16'hFFFF, 1'b1},
        '{ROW_PIXEL_KNOWN, '0, 16'd0, 8'h00, 8'h00, 16'h0000, 1'b1},
        '{ROW_CFG, bpcg_pkg::CFG_ORIGIN_X, 16'd255, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_CFG, bpcg_pkg::CFG_ORIGIN_Y, 16'd255, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_CFG, bpcg_pkg::CFG_WIDTH, 16'd2, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_CFG, bpcg_pkg::CFG_HEIGHT, 16'd2, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_CFG, bpcg_pkg::CFG_FG_COLOR, 16'h0000, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_PIXEL_KNOWN, '0, 16'd1, 8'hFF, 8'hFF, 16'h0000, 1'b0},
        '{ROW_PIXEL_KNOWN, '0, 16'd1, 8'h00, 8'hFF, 16'h0000, 1'b0},
        '{ROW_PIXEL_KNOWN, '0, 16'd0, 8'hFF, 8'h00, 16'h0000, 1'b0},
        '{ROW_PIXEL_KNOWN, '0, 16'd1, 8'h00, 8'h00, 16'h0000, 1'b1},
        '{ROW_CFG, bpcg_pkg::CFG_FG_COLOR, 16'hFFFF, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_CFG, bpcg_pkg::CFG_WIDTH, 16'd0, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_CFG, bpcg_pkg::CFG_HEIGHT, 16'd0, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_PIXEL_KNOWN, '0, 16'd1, 8'hFF, 8'hFF, 16'hFFFF, 1'b1},
        '{ROW_PIXEL_KNOWN, '0, 16'd0, 8'hFF, 8'hFF, 16'h0000, 1'b1},
        '{ROW_CFG, bpcg_pkg::CFG_ORIGIN_X, 16'd0, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_CFG, bpcg_pkg::CFG_ORIGIN_Y, 16'd0, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_CFG, bpcg_pkg::CFG_WIDTH, 16'd255, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_CFG, bpcg_pkg::CFG_HEIGHT, 16'd255, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_CFG, bpcg_pkg::CFG_FG_COLOR, 16'hA55A, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_PIXEL, '0, 16'd1, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_PIXEL, '0, 16'd0, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_PIXEL, '0, 16'd1, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_PIXEL, '0, 16'd1, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_CFG, bpcg_pkg::CFG_WIDTH, 16'd2, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_PIXEL, '0, 16'd1, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_PIXEL, '0, 16'd1, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_PIXEL, '0, 16'd0, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_CFG, bpcg_pkg::CFG_ORIGIN_X, 16'h0080, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_CFG, bpcg_pkg::CFG_FG_COLOR, 16'h5AA5, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_PIXEL, '0, 16'd1, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_PIXEL, '0, 16'd0, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_PIXEL, '0, 16'd1, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_CFG, bpcg_pkg::CFG_HEIGHT, 16'd1, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_PIXEL, '0, 16'd1, 8'h00, 8'h00, 16'h0000, 1'b0},
        '{ROW_PIXEL, '0, 16'd0, 8'h00, 8'h00, 16'h0000, 1'b0}
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [bpcg_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [bpcg_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [7:0]                      m_axis_tdata;
    logic                            m_axis_tlast;
    logic [1:0]                      m_axis_tuser;

    // Shadow of the block's registers and position counters.
    logic [7:0]  origin_x_reg = 8'd0;
    logic [7:0]  origin_y_reg = 8'd0;
    logic [7:0]  width_reg    = 8'd1;
    logic [7:0]  height_reg   = 8'd1;
    logic [15:0] fg_reg       = 16'hFFFF;
    logic [7:0]  col_pos      = 8'd0;
    logic [7:0]  row_pos      = 8'd0;

    t_lcd_byte due_bytes [$];

    int  mismatches       = 0;
    int  pixels_sent      = 0;
    int  images_done      = 0;
    int  settings_written = 0;
    int  cycle_count      = 0;
    bit  sender_steady    = 1'b0;
    bit  sink_steady      = 1'b0;

    bitmap_pixel_command_generator #(
        .COORD_BITS(8)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),   // [0] pixel_on, [7:1] zero
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),   // [7:0] out_byte
        .m_axis_tlast (m_axis_tlast),   // pixel_last
        .m_axis_tuser (m_axis_tuser)    // [0] is_data, [1] image_last
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: no progress after %0d cycles", $time, CYCLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // Works out the addresses, colour and end-of-image flag of the next pixel,
    // then moves the position counters on. A counter wraps once count + 1
    // reaches its limit, so a limit of zero behaves as one.
    task automatic plan_pixel_write(input logic on, output logic [7:0] x,
                                    output logic [7:0] y, output logic [15:0] colour,
                                    output logic last);
        logic row_end;
        logic col_end;
        row_end = ({1'b0, col_pos} + 9'd1) >= {1'b0, width_reg};
        col_end = ({1'b0, row_pos} + 9'd1) >= {1'b0, height_reg};
        x       = origin_x_reg + col_pos;
        y       = origin_y_reg + row_pos;
        colour  = on ? fg_reg : 16'h0000;
        last    = row_end && col_end;
        if (row_end) begin
            col_pos = 8'd0;
            row_pos = col_end ? 8'd0 : row_pos + 8'd1;
        end else begin
            col_pos = col_pos + 8'd1;
        end
    endtask

    // Queues the nine bytes that write one pixel.
    task automatic queue_write_sequence(input logic [7:0] x, input logic [7:0] y,
                                        input logic [15:0] colour, input logic last);
        due_bytes.push_back('{bpcg_pkg::CMD_COLUMN, 1'b0, 1'b0, 1'b0});
        due_bytes.push_back('{bpcg_pkg::ZERO_BYTE, 1'b1, 1'b0, 1'b0});
        due_bytes.push_back('{x, 1'b1, 1'b0, 1'b0});
        due_bytes.push_back('{bpcg_pkg::CMD_ROW, 1'b0, 1'b0, 1'b0});
        due_bytes.push_back('{bpcg_pkg::ZERO_BYTE, 1'b1, 1'b0, 1'b0});
        due_bytes.push_back('{y, 1'b1, 1'b0, 1'b0});
        due_bytes.push_back('{bpcg_pkg::CMD_WRITE, 1'b0, 1'b0, 1'b0});
        due_bytes.push_back('{colour[15:8], 1'b1, 1'b0, 1'b0});
        due_bytes.push_back('{colour[7:0], 1'b1, 1'b1, last});
    endtask

    // Offers one bitmap bit, after a random gap unless the sender is steady, and records
    // its bytes once the word has been taken. A known row supplies its own expected bytes.
    task automatic send_pixel(input logic on, input logic known, input t_script_row row);
        int unsigned gap;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] colour;
        logic        last;
        gap = sender_steady ? 0 : $urandom_range(0, 6);
        i_cfg_we <= 1'b0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, on};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        plan_pixel_write(on, x, y, colour, last);
        if (known) begin
            queue_write_sequence(row.x, row.y, row.colour, row.last);
        end else begin
            queue_write_sequence(x, y, colour, last);
        end
        pixels_sent++;
    endtask

    // Stops offering words and waits until every expected byte has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (due_bytes.size() != 0) @(posedge i_clk);
    endtask

    // Writes one register; the block is idle whenever this is called.
    task automatic write_reg(input logic [bpcg_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [15:0] value);
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        case (idx)
            bpcg_pkg::CFG_ORIGIN_X: origin_x_reg = value[7:0];
            bpcg_pkg::CFG_ORIGIN_Y: origin_y_reg = value[7:0];
            bpcg_pkg::CFG_WIDTH:    width_reg    = value[7:0];
            bpcg_pkg::CFG_HEIGHT:   height_reg   = value[7:0];
            bpcg_pkg::CFG_FG_COLOR: fg_reg       = value;
            default: ;
        endcase
        settings_written++;
    endtask

    // Origins lean towards the edges so that address wrap comes up often.
    function automatic logic [7:0] pick_origin();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly small images so that many complete; now and then zero or full size.
    function automatic logic [7:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [15:0] pick_colour();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Checks one word taken from the output against the oldest expectation.
    task automatic take_byte();
        t_lcd_byte want;
        if (due_bytes.size() == 0) begin
            $display("%0t: unexpected byte, expected none, got %h data=%b pix=%b img=%b",
                     $time, m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]);
            mismatches++;
        end else begin
            want = due_bytes.pop_front();
            if (m_axis_tdata !== want.value || m_axis_tuser[0] !== want.is_data
                    || m_axis_tlast !== want.pixel_end || m_axis_tuser[1] !== want.image_end) begin
                $display("%0t: byte mismatch, expected %h data=%b pix=%b img=%b,",
                         $time, want.value, want.is_data, want.pixel_end, want.image_end);
                $display("    got %h data=%b pix=%b img=%b",
                         m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]);
                mismatches++;
            end
            if (want.image_end) begin
                images_done++;
            end
        end
    endtask

    // Output side: unless the sink is steady, stalls a random number of cycles before each word.
    initial begin
        int unsigned stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = sink_steady ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            take_byte();
        end
    end

    // Main sequence: reset, directed script, random phases, drain and verdict.
    initial begin
        int unsigned density;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            if (script[i].kind == ROW_CFG) begin
                wait_drained();
                write_reg(script[i].idx, script[i].value);
            end else begin
                send_pixel(script[i].value[0], script[i].kind == ROW_PIXEL_KNOWN, script[i]);
            end
        end

        // Each phase reprograms every register while idle, leaving the
        // counters wherever the previous phase stopped.
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            wait_drained();
            write_reg(bpcg_pkg::CFG_ORIGIN_X, {8'd0, pick_origin()});
            write_reg(bpcg_pkg::CFG_ORIGIN_Y, {8'd0, pick_origin()});
            write_reg(bpcg_pkg::CFG_WIDTH, {8'd0, pick_size()});
            write_reg(bpcg_pkg::CFG_HEIGHT, {8'd0, pick_size()});
            write_reg(bpcg_pkg::CFG_FG_COLOR, pick_colour());
            sender_steady = ($urandom_range(0, 3) == 0);
            sink_steady   = ($urandom_range(0, 3) == 0);
            density       = $urandom_range(0, 4);
            repeat (PIXELS_PER_PHASE) begin
                send_pixel($urandom_range(0, 3) < density, 1'b0, '0);
            end
        end

        i_cfg_we <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bitmap bits under %0d register writes; %0d images completed.",
                 pixels_sent, settings_written, images_done);
        $display("Byte mismatches: %0d, expected bytes outstanding: %0d.",
                 mismatches, due_bytes.size());
        if (mismatches == 0 && due_bytes.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
